// ----- design/rational_arithmetic_unit_defines.svh -----
// Assertion macros for the rational arithmetic unit.
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define RAU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RAU_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/rau_pkg.sv -----
package rau_pkg;

  localparam int unsigned OPERAND_WIDTH = 16;
  localparam int unsigned OP_W = 2;
  localparam int unsigned RES_NUM_W = 32;
  localparam int unsigned RES_DEN_W = 30;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef struct packed {
    op_t                      opcode;
    logic [OPERAND_WIDTH-1:0] a_num;
    logic [OPERAND_WIDTH-2:0] a_den;
    logic [OPERAND_WIDTH-1:0] b_num;
    logic [OPERAND_WIDTH-2:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic [RES_NUM_W-1:0] res_num;
    logic [RES_DEN_W-1:0] res_den;
    logic                 undefined;
  } out_item_t;

endpackage

// ----- design/rau_front.sv -----
// Operand decode and cross products; hands magnitudes to the queue.
module rau_front #(
  parameter int unsigned OW = 16,
  parameter int unsigned MW = 2 * OW + 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [1:0]    opcode,
  input  logic [OW-1:0] a_num,
  input  logic [OW-2:0] a_den,
  input  logic [OW-1:0] b_num,
  input  logic [OW-2:0] b_den,
  output logic          busy,
  output logic          q_valid,
  input  logic          q_ready,
  output logic [MW-1:0] q_nmag,
  output logic [MW-1:0] q_dmag,
  output logic          q_neg,
  output logic          q_undef,
  output logic          q_zero
);
  localparam int unsigned PW = 2 * OW;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MUL  = 3'b010,
    F_SUM  = 3'b100
  } fst_t;

  fst_t fst_r, fst_nxt;
  logic [1:0] op_r;
  logic signed [OW-1:0] an_r, bn_r;
  logic signed [OW:0] ad_r, bd_r;
  logic signed [PW:0] p1_r, p2_r, p3_r;
  logic signed [PW+1:0] num_s, den_s;
  logic [PW+1:0] nm, dm;
  logic v_r;
  logic [MW-1:0] nmag_r, dmag_r;
  logic neg_r, und_r, zero_r;

  assign busy = (fst_r != F_IDLE);

  always_comb begin
    fst_nxt = fst_r;
    case (fst_r)
      F_IDLE: if (start) fst_nxt = F_MUL;
      F_MUL: fst_nxt = F_SUM;
      F_SUM: if (!v_r || q_ready) fst_nxt = F_IDLE;
      default: fst_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    case (rau_pkg::op_t'(op_r))
      rau_pkg::OP_ADD: num_s = p1_r + p2_r;
      rau_pkg::OP_SUB: num_s = p1_r - p2_r;
      rau_pkg::OP_MUL: num_s = {p2_r[PW], p2_r};
      default: num_s = {p1_r[PW], p1_r};
    endcase
    den_s = {p3_r[PW], p3_r};
    nm = num_s[PW+1] ? -num_s : num_s;
    dm = den_s[PW+1] ? -den_s : den_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fst_r <= F_IDLE;
      v_r <= 1'b0;
    end else begin
      fst_r <= fst_nxt;
      if (fst_r == F_SUM && (!v_r || q_ready)) v_r <= 1'b1;
      else if (q_ready) v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fst_r == F_IDLE && start) begin
      op_r <= opcode;
      an_r <= a_num;
      bn_r <= b_num;
      ad_r <= {2'b00, a_den};
      bd_r <= {2'b00, b_den};
    end
    if (fst_r == F_MUL) begin
      p1_r <= (PW+1)'(an_r * bd_r);
      if (op_r == rau_pkg::OP_MUL) p2_r <= (PW+1)'(an_r * bn_r);
      else p2_r <= (PW+1)'(bn_r * ad_r);
      if (op_r == rau_pkg::OP_DIV) p3_r <= (PW+1)'(ad_r * bn_r);
      else p3_r <= (PW+1)'(ad_r * bd_r);
    end
    if (fst_r == F_SUM && (!v_r || q_ready)) begin
      nmag_r <= MW'(nm);
      dmag_r <= MW'(dm);
      neg_r <= num_s[PW+1] ^ den_s[PW+1];
      und_r <= (den_s == '0);
      zero_r <= (num_s == '0);
    end
  end

  assign q_valid = v_r;
  assign q_nmag = nmag_r;
  assign q_dmag = dmag_r;
  assign q_neg = neg_r;
  assign q_undef = und_r;
  assign q_zero = zero_r;
endmodule

// ----- design/rau_back.sv -----
// GCD by iterated restoring remainder, then two restoring divisions.
module rau_back #(
  parameter int unsigned MW = 33
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_ready,
  input  logic [MW-1:0]       q_nmag,
  input  logic [MW-1:0]       q_dmag,
  input  logic                q_neg,
  input  logic                q_undef,
  input  logic                q_zero,
  output logic                out_valid,
  output rau_pkg::out_item_t  out_item
);
  localparam int unsigned CW = $clog2(MW + 1);

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_REM  = 6'b000010,
    B_SWAP = 6'b000100,
    B_DN   = 6'b001000,
    B_DD   = 6'b010000,
    B_OUT  = 6'b100000
  } bst_t;

  bst_t st_r, st_nxt;
  logic [MW-1:0] y_r, n_r, d_r, g_r, quo_r, nq_r;
  logic [MW:0] rem_r;
  logic [MW-1:0] dvd_r;
  logic [CW-1:0] cnt_r;
  logic neg_r;
  logic [MW:0] trial;
  logic [MW-1:0] dvs;
  logic last;
  logic ov_r;
  rau_pkg::out_item_t oi_r;

  assign q_ready = (st_r == B_IDLE);
  assign last = (cnt_r == CW'(MW - 1));
  assign dvs = (st_r == B_REM) ? y_r : g_r;
  assign trial = {rem_r[MW-1:0], dvd_r[MW-1]} - {1'b0, dvs};

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      B_IDLE: if (q_valid) begin
        if (q_undef || q_zero) st_nxt = B_OUT;
        else st_nxt = B_REM;
      end
      B_REM: if (last) st_nxt = B_SWAP;
      B_SWAP: st_nxt = (rem_r == '0) ? B_DN : B_REM;
      B_DN: if (last) st_nxt = B_DD;
      B_DD: if (last) st_nxt = B_OUT;
      B_OUT: st_nxt = B_IDLE;
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= (st_r == B_OUT);
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      B_IDLE: if (q_valid) begin
        y_r <= q_dmag;
        n_r <= q_nmag;
        d_r <= q_dmag;
        neg_r <= q_neg;
        dvd_r <= q_nmag;
        rem_r <= '0;
        cnt_r <= '0;
        oi_r.undefined <= q_undef;
        oi_r.res_num <= q_undef ? 32'd1 : 32'd0;
        oi_r.res_den <= q_undef ? 30'd0 : 30'd1;
      end
      B_REM, B_DN, B_DD: begin
        dvd_r <= {dvd_r[MW-2:0], 1'b0};
        quo_r <= {quo_r[MW-2:0], ~trial[MW]};
        rem_r <= trial[MW] ? {rem_r[MW-1:0], dvd_r[MW-1]} : trial;
        cnt_r <= last ? '0 : cnt_r + 1'b1;
        if (last && st_r == B_DN) begin
          nq_r <= {quo_r[MW-2:0], ~trial[MW]};
          dvd_r <= d_r;
          rem_r <= '0;
        end
        if (last && st_r == B_DD) begin
          oi_r.res_num <= neg_r ? 32'(-nq_r) : 32'(nq_r);
          oi_r.res_den <= 30'({quo_r[MW-2:0], ~trial[MW]});
        end
      end
      B_SWAP: begin
        if (rem_r == '0) begin
          g_r <= y_r;
          dvd_r <= n_r;
        end else begin
          y_r <= rem_r[MW-1:0];
          dvd_r <= y_r;
        end
        rem_r <= '0;
      end
      default: ;
    endcase
  end

  assign out_valid = ov_r;
  assign out_item = oi_r;
endmodule

// ----- design/rational_arithmetic_unit.sv -----
// Rational arithmetic unit: a transfer happens at a rising edge with start
// high and busy low and carries an opcode and two fractions in in_item; one
// reduced fraction comes back later in out_item for exactly one cycle with
// out_strobe high. The receiver cannot stall it, so take it in that cycle.
// A front part forms the cross products in its F_MUL state and the sums in
// F_SUM, and parks the magnitudes in a one-entry queue; busy drops once the
// queue takes them, so busy stays high while the queue still holds the
// previous item and the back part has not yet taken it. The back part runs
// a Euclidean GCD with a bit-serial remainder unit (one quotient bit per
// cycle, and a swap state after each step) and then two exact divisions.
// The number of GCD steps sets the time to the strobe; zero and undefined
// results skip the iteration and the divisions.
`include "rational_arithmetic_unit_defines.svh"
module rational_arithmetic_unit (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  rau_pkg::in_item_t in_item,
  output logic out_strobe,
  output rau_pkg::out_item_t out_item
);
  localparam int unsigned OW = rau_pkg::OPERAND_WIDTH;
  localparam int unsigned MW = 2 * OW + 1;
  logic q_valid, q_ready, q_neg, q_undef, q_zero;
  logic [MW-1:0] q_nmag, q_dmag;

  rau_front #(.OW(OW), .MW(MW)) u_front (
    .clk, .rst_n, .start, .opcode(in_item.opcode), .a_num(in_item.a_num),
    .a_den(in_item.a_den), .b_num(in_item.b_num), .b_den(in_item.b_den), .busy,
    .q_valid, .q_ready, .q_nmag, .q_dmag, .q_neg, .q_undef, .q_zero
  );

  rau_back #(.MW(MW)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_nmag, .q_dmag, .q_neg,
    .q_undef, .q_zero, .out_valid(out_strobe), .out_item
  );

  `RAU_ASSERT_NEXT(a_strobe_pulse, clk, rst_n, out_strobe, !out_strobe)
  `RAU_ASSERT_IMPL(a_undef_form, clk, rst_n, out_strobe && out_item.undefined, out_item.res_den == '0)
  `RAU_ASSERT_NEXT(a_take_busy, clk, rst_n, start && !busy, busy)
endmodule
